### hw/rtl/tsom_pkg.sv
// tsom_pkg: sizes, command and status codes and address helpers for the
// three-stack shared memory core. No dependencies; imported by the core.
package tsom_pkg;

  // memory geometry
  localparam int TOTAL_ENTRIES = 48;
  localparam int NUM_STACKS    = 3;
  localparam int PART_SIZE     = TOTAL_ENTRIES / NUM_STACKS;
  localparam int ADDR_W        = $clog2(TOTAL_ENTRIES);
  localparam int CNT_W         = $clog2(PART_SIZE + 1);

  // field widths
  localparam int CMD_W    = 2;
  localparam int SEL_W    = 2;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH    = 2'd0,
    CMD_POP     = 2'd1,
    CMD_DISPLAY = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // first word of a stack's partition
  function automatic logic [ADDR_W-1:0] part_base(input logic [SEL_W-1:0] sel);
    logic [ADDR_W+SEL_W-1:0] prod;
    begin
      prod = (ADDR_W+SEL_W)'(sel) * (ADDR_W+SEL_W)'(PART_SIZE);
      part_base = prod[ADDR_W-1:0];
    end
  endfunction

endpackage

### hw/rtl/three_stacks_one_memory_core.sv
// three_stacks_one_memory_core: three fixed-partition LIFO stacks in one
// synchronous word memory. Depends on tsom_pkg.
//
// A transaction is taken when start is high and busy is low. Push and the
// error cases (overflow, underflow, display of an empty stack) hold busy low,
// so one can be taken every cycle. Pop holds busy while the registered read
// of the top word returns. Display of a stack holding n entries streams one
// entry per cycle from the memory read port. Each result appears on the out_
// ports for one cycle, marked by out_valid, from the out_ registers, with pop
// and display data passing first through the memory read register;
// the receiver cannot stall, so every strobe must be captured.
module three_stacks_one_memory_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [tsom_pkg::CMD_W-1:0]      in_cmd,
  input  logic [tsom_pkg::SEL_W-1:0]      in_stack_sel,
  input  logic signed [tsom_pkg::DATA_W-1:0] in_push_value,
  output logic                            out_valid,
  output logic [tsom_pkg::STATUS_W-1:0]   out_status,
  output logic signed [tsom_pkg::DATA_W-1:0] out_value,
  output logic                            out_last
);
  import tsom_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_DISP = 3'b100
  } state_t;

  // control state
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    fill_r   [NUM_STACKS];
  logic [CNT_W-1:0]    fill_nxt [NUM_STACKS];
  logic [ADDR_W-1:0]   disp_addr_r, disp_addr_nxt;
  logic [CNT_W-1:0]    disp_left_r, disp_left_nxt;

  // result registers
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [DATA_W-1:0]   out_value_r, out_value_nxt;
  logic                out_last_r, out_last_nxt;

  // memory port signals
  logic [DATA_W-1:0]   mem [TOTAL_ENTRIES];
  logic                mem_we, mem_re;
  logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
  logic [DATA_W-1:0]   mem_rdata_r;

  // decode of the offered transaction
  logic                cmd_ok, sel_ok;
  logic [CNT_W-1:0]    cnt_sel;
  logic [ADDR_W-1:0]   base_sel, top_addr;

  assign cmd_ok   = in_cmd inside {CMD_PUSH, CMD_POP, CMD_DISPLAY};
  assign sel_ok   = in_stack_sel inside {[0:NUM_STACKS-1]};
  assign base_sel = part_base(in_stack_sel);
  assign top_addr = base_sel + ADDR_W'(cnt_sel) - ADDR_W'(1);

  // count of the addressed stack, zero for an unused selector
  always_comb begin
    cnt_sel = '0;
    for (int i = 0; i < NUM_STACKS; i++) begin
      if (in_stack_sel == SEL_W'(i)) begin
        cnt_sel = fill_r[i];
      end
    end
  end

  // sequencer and next-state logic
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    disp_addr_nxt  = disp_addr_r;
    disp_left_nxt  = disp_left_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = base_sel + ADDR_W'(cnt_sel);
    mem_raddr      = top_addr;

    case (state_r)
      S_IDLE: begin
        if (start && cmd_ok && sel_ok) begin
          case (cmd_t'(in_cmd))
            CMD_PUSH: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              if (cnt_sel == CNT_W'(PART_SIZE)) begin
                out_status_nxt = ST_OVERFLOW;
                out_value_nxt  = '0;
              end else begin
                mem_we         = 1'b1;
                fill_nxt[in_stack_sel] = cnt_sel + CNT_W'(1);
                out_status_nxt = ST_DONE;
                out_value_nxt  = in_push_value;
              end
            end
            CMD_POP: begin
              if (cnt_sel == '0) begin
                out_valid_nxt  = 1'b1;
                out_last_nxt   = 1'b1;
                out_status_nxt = ST_UNDERFLOW;
                out_value_nxt  = '0;
              end else begin
                mem_re    = 1'b1;
                fill_nxt[in_stack_sel] = cnt_sel - CNT_W'(1);
                state_nxt = S_POP;
              end
            end
            CMD_DISPLAY: begin
              if (cnt_sel == '0) begin
                out_valid_nxt  = 1'b1;
                out_last_nxt   = 1'b1;
                out_status_nxt = ST_EMPTY;
                out_value_nxt  = '0;
              end else begin
                mem_re        = 1'b1;
                disp_addr_nxt = top_addr - ADDR_W'(1);
                disp_left_nxt = cnt_sel;
                state_nxt     = S_DISP;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      // popped word arrives from the read register
      S_POP: begin
        out_valid_nxt  = 1'b1;
        out_last_nxt   = 1'b1;
        out_status_nxt = ST_DONE;
        out_value_nxt  = mem_rdata_r;
        state_nxt      = S_IDLE;
      end
      // stream one entry per cycle, issuing the next read alongside
      S_DISP: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_DONE;
        out_value_nxt  = mem_rdata_r;
        out_last_nxt   = (disp_left_r == CNT_W'(1));
        mem_raddr      = disp_addr_r;
        if (disp_left_r == CNT_W'(1)) begin
          state_nxt = S_IDLE;
        end else begin
          mem_re        = 1'b1;
          disp_addr_nxt = disp_addr_r - ADDR_W'(1);
          disp_left_nxt = disp_left_r - CNT_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fill_r      <= fill_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    disp_addr_r  <= disp_addr_nxt;
    disp_left_r  <= disp_left_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  // stack memory: one write and one registered read per cycle; a write and a
  // read never target the same cycle, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_push_value;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;

endmodule
